// File: rtl/core/gasp_pkg.sv
`default_nettype none
package gasp_pkg;
   typedef enum logic [1:0] {
      REQ_SET_CELL = 2'd0,
      REQ_SEARCH   = 2'd1,
      REQ_READ_WAY = 2'd2,
      REQ_ADVANCE  = 2'd3
   } req_kind_type;

   localparam logic CSR_WIDTH_IDX  = 1'b0;
   localparam logic CSR_HEIGHT_IDX = 1'b1;
   localparam int   CSR_IDX_BITS   = 1;
   localparam int   CSR_DATA_BITS  = 6;
   localparam int   COORD_BITS     = 5;
   localparam int   LEN_BITS       = 11;
endpackage
`default_nettype wire

// File: rtl/core/grid_astar_path_search.sv
// channel | direction | ports
// request | in        | start, busy, req_type, req_cell_x/y, req_blocked, req_goal_x/y
// result  | out       | rsp_strobe, rsp_found, rsp_path_length, rsp_way_x/y/valid
// csr     | in        | csr_valid, csr_ready, csr_index, csr_data
//
// waypoint read, advance or set cell: the request passes S_WAY_RD and then S_WAY_OUT,
// which registers the result strobe; the next word is taken once the block is idle again
// search: a clearing sweep of one cell a cycle over all cells and an init step, then
// per expansion a scan of the open list (each entry read in turn, one shared read port),
// a pick step, a shift of each entry behind the chosen one down by one, and a check
// of each neighbour on the grid (with a write when it is updated, skipped when off the grid);
// once the goal is taken, each path cell is traced and then copied, and the result is answered
// a clearing pass of one cell a cycle over all 2**(XB+YB) cells (1024 at the defaults)
// runs after reset, busy held high meanwhile
// result strobe lasts one cycle; the receiver cannot stall it
`default_nettype none
module grid_astar_path_search #(
   parameter int MAX_WIDTH  = 32,
   parameter int MAX_HEIGHT = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [1:0]                         req_type,
   input  wire logic [gasp_pkg::COORD_BITS-1:0]    req_cell_x,
   input  wire logic [gasp_pkg::COORD_BITS-1:0]    req_cell_y,
   input  wire logic                               req_blocked,
   input  wire logic [gasp_pkg::COORD_BITS-1:0]    req_goal_x,
   input  wire logic [gasp_pkg::COORD_BITS-1:0]    req_goal_y,
   output logic                                    rsp_strobe,
   output logic                                    rsp_found,
   output logic [gasp_pkg::LEN_BITS-1:0]           rsp_path_length,
   output logic [gasp_pkg::COORD_BITS-1:0]         rsp_way_x,
   output logic [gasp_pkg::COORD_BITS-1:0]         rsp_way_y,
   output logic                                    rsp_way_valid,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [gasp_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [gasp_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import gasp_pkg::*;

   localparam int XB    = $clog2(MAX_WIDTH);
   localparam int YB    = $clog2(MAX_HEIGHT);
   localparam int AB    = XB + YB;
   localparam int CELLS = 1 << AB;   // address space: rows sit on a power-of-two stride
   localparam int CB    = AB + 1;   // counts up to cells, and cost values
   localparam logic [CB-1:0] UNREACH = '1;

   // cell record: visited, cost, estimate, parent, parent valid
   localparam int RECB = 1 + CB + CB + AB + 1;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_WAY_RD, S_WAY_OUT,
      S_S_CLR, S_S_INIT,
      S_SCAN_A, S_SCAN_B, S_SCAN_C, S_PICK, S_SHIFT_A, S_SHIFT_B,
      S_NB_SEL, S_NB_RD, S_NB_CHK, S_NB_WR,
      S_TR_RD, S_TR_WR, S_TR_CP_A, S_TR_CP_B, S_DONE
   } state_type;

   state_type state_ff;

   logic [CSR_DATA_BITS-1:0] gw_ff, gh_ff;
   logic [CB-1:0]  clr_ff;
   logic [CB-1:0]  open_cnt_ff, scan_ff, best_ff, sh_ff;
   logic [CB-1:0]  best_f_ff;
   logic [AB-1:0]  node_ff, sx_cell_ff, g_cell_ff, nb_ff;
   logic [CB-1:0]  node_g_ff;
   logic [1:0]     dir_ff;
   logic [XB-1:0]  gx_ff;
   logic [YB-1:0]  gy_ff;
   logic [CB-1:0]  path_cnt_ff, tr_len_ff, tr_i_ff;
   logic [AB-1:0]  tr_p_ff;
   logic [AB-1:0]  way_idx_ff;
   logic           found_ff;

   // effective grid dimensions
   logic [8:0] eff_w, eff_h;
   always_comb begin
      eff_w = (gw_ff == '0) ? 9'd1 : ({3'd0, gw_ff} > 9'(MAX_WIDTH) ? 9'(MAX_WIDTH)
                                                                   : {3'd0, gw_ff});
      eff_h = (gh_ff == '0) ? 9'd1 : ({3'd0, gh_ff} > 9'(MAX_HEIGHT) ? 9'(MAX_HEIGHT)
                                                                    : {3'd0, gh_ff});
   end

   // obstacle map
   logic          ob_we, ob_wd, ob_rd;
   logic [AB-1:0] ob_wa, ob_ra;
   gasp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obst (
      .clock, .wr_en(ob_we), .wr_addr(ob_wa), .wr_data(ob_wd),
      .rd_addr(ob_ra), .rd_data(ob_rd));

   // per-cell search record
   logic            rc_we;
   logic [AB-1:0]   rc_wa, rc_ra;
   logic [RECB-1:0] rc_wd, rc_rd;
   gasp_ram #(.WIDTH(RECB), .DEPTH(CELLS)) u_rec (
      .clock, .wr_en(rc_we), .wr_addr(rc_wa), .wr_data(rc_wd),
      .rd_addr(rc_ra), .rd_data(rc_rd));

   logic          rd_vis, rd_pv;
   logic [CB-1:0] rd_g, rd_f;
   logic [AB-1:0] rd_par;
   assign {rd_vis, rd_g, rd_f, rd_par, rd_pv} = rc_rd;

   // open list
   logic          ol_we;
   logic [AB-1:0] ol_wa, ol_ra, ol_wd, ol_rd;
   gasp_ram #(.WIDTH(AB), .DEPTH(CELLS)) u_open (
      .clock, .wr_en(ol_we), .wr_addr(ol_wa), .wr_data(ol_wd),
      .rd_addr(ol_ra), .rd_data(ol_rd));

   // trace buffer and stored path
   logic          tb_we;
   logic [AB-1:0] tb_wa, tb_ra, tb_wd, tb_rd;
   gasp_ram #(.WIDTH(AB), .DEPTH(CELLS)) u_trace (
      .clock, .wr_en(tb_we), .wr_addr(tb_wa), .wr_data(tb_wd),
      .rd_addr(tb_ra), .rd_data(tb_rd));

   logic          ps_we;
   logic [AB-1:0] ps_wa, ps_ra, ps_wd, ps_rd;
   gasp_ram #(.WIDTH(AB), .DEPTH(CELLS)) u_path (
      .clock, .wr_en(ps_we), .wr_addr(ps_wa), .wr_data(ps_wd),
      .rd_addr(ps_ra), .rd_data(ps_rd));

   // neighbour address and bounds
   logic [XB-1:0] node_x;
   logic [YB-1:0] node_y;
   logic          nb_ok;
   logic [AB-1:0] nb_cell;
   assign node_x = node_ff[XB-1:0];
   assign node_y = node_ff[AB-1:XB];
   always_comb begin
      nb_ok   = 1'b0;
      nb_cell = node_ff;
      case (dir_ff)
         2'd0: begin
            nb_ok   = ({1'b0, 8'(node_x)} + 9'd1) < eff_w;
            nb_cell = {node_y, XB'(node_x + 1'b1)};
         end
         2'd1: begin
            nb_ok   = ({1'b0, 8'(node_y)} + 9'd1) < eff_h;
            nb_cell = {YB'(node_y + 1'b1), node_x};
         end
         2'd2: begin
            nb_ok   = node_x != '0;
            nb_cell = {node_y, XB'(node_x - 1'b1)};
         end
         default: begin
            nb_ok   = node_y != '0;
            nb_cell = {YB'(node_y - 1'b1), node_x};
         end
      endcase
   end

   // manhattan estimate of the neighbour held in nb_ff
   logic [XB-1:0] dx;
   logic [YB-1:0] dy;
   logic [CB-1:0] nb_f;
   always_comb begin
      dx   = (nb_ff[XB-1:0] > gx_ff) ? nb_ff[XB-1:0] - gx_ff : gx_ff - nb_ff[XB-1:0];
      dy   = (nb_ff[AB-1:XB] > gy_ff) ? nb_ff[AB-1:XB] - gy_ff : gy_ff - nb_ff[AB-1:XB];
      nb_f = node_g_ff + CB'(1) + CB'(dx) + CB'(dy);
   end

   logic          req_in_grid, goal_in_grid;
   logic          acc;
   assign acc          = start && !busy;
   assign req_in_grid  = {4'd0, req_cell_x} < eff_w && {4'd0, req_cell_y} < eff_h;
   assign goal_in_grid = {4'd0, req_goal_x} < eff_w && {4'd0, req_goal_y} < eff_h;

   logic [AB-1:0] req_cell, req_goal;
   assign req_cell = {YB'(req_cell_y), XB'(req_cell_x)};
   assign req_goal = {YB'(req_goal_y), XB'(req_goal_x)};

   logic [CB-1:0] way_idx_ext;
   assign way_idx_ext = {1'b0, way_idx_ff};

   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;

   // memory port control
   always_comb begin
      ob_we = 1'b0; ob_wa = req_cell; ob_wd = req_blocked; ob_ra = nb_ff;
      rc_we = 1'b0; rc_wa = nb_ff; rc_wd = {1'b0, UNREACH, UNREACH, {AB{1'b0}}, 1'b0};
      rc_ra = nb_ff;
      ol_we = 1'b0; ol_wa = open_cnt_ff[AB-1:0]; ol_wd = nb_ff; ol_ra = scan_ff[AB-1:0];
      tb_we = 1'b0; tb_wa = tr_len_ff[AB-1:0]; tb_wd = tr_p_ff; tb_ra = tr_i_ff[AB-1:0];
      ps_we = 1'b0; ps_wa = tr_i_ff[AB-1:0]; ps_wd = tb_rd; ps_ra = way_idx_ff;
      case (state_ff)
         S_CLR: begin
            ob_we = 1'b1; ob_wa = clr_ff[AB-1:0]; ob_wd = 1'b0;
            rc_we = 1'b1; rc_wa = clr_ff[AB-1:0];
         end
         S_IDLE: begin
            if (acc && req_kind_type'(req_type) == REQ_SET_CELL && req_in_grid) begin
               ob_we = 1'b1;
            end
         end
         S_S_CLR: begin
            rc_we = 1'b1; rc_wa = clr_ff[AB-1:0];
            ob_we = clr_ff == '0 || clr_ff == CB'(1);
            ob_wa = (clr_ff == '0) ? sx_cell_ff : g_cell_ff; ob_wd = 1'b0;
         end
         S_S_INIT: begin
            rc_we = 1'b1; rc_wa = sx_cell_ff;
            rc_wd = {1'b1, {CB{1'b0}}, UNREACH, {AB{1'b0}}, 1'b0};
            ol_we = 1'b1; ol_wa = '0; ol_wd = sx_cell_ff;
         end
         S_SCAN_B: rc_ra = ol_rd;
         S_PICK: begin
            ol_ra = sh_ff[AB-1:0];
            rc_ra = node_ff;
         end
         S_SHIFT_A: ol_ra = sh_ff[AB-1:0];
         S_SHIFT_B: begin
            ol_we = 1'b1; ol_wa = AB'(sh_ff - CB'(1)); ol_wd = ol_rd;
            ol_ra = sh_ff[AB-1:0];
            rc_ra = node_ff;
         end
         S_NB_SEL: begin
            rc_ra = nb_cell; ob_ra = nb_cell;
         end
         S_NB_WR: begin
            rc_we = 1'b1; rc_wa = nb_ff;
            rc_wd = {1'b0, CB'(node_g_ff + CB'(1)), nb_f, node_ff, 1'b1};
            ol_we = rd_g == UNREACH && open_cnt_ff < CB'(CELLS);
         end
         S_TR_RD: rc_ra = tr_p_ff;
         S_TR_WR: begin
            tb_we = 1'b1;
         end
         S_TR_CP_A: tb_ra = AB'(tr_len_ff - CB'(1) - tr_i_ff);
         S_TR_CP_B: ps_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLR;
         clr_ff      <= '0;
         gw_ff       <= 6'd32;
         gh_ff       <= 6'd32;
         path_cnt_ff <= '0;
         way_idx_ff  <= '0;
         open_cnt_ff <= '0;
         rsp_strobe  <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDTH_IDX:  gw_ff <= csr_data;
               CSR_HEIGHT_IDX: gh_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + CB'(1);
               if (clr_ff == CB'(CELLS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (acc) begin
                  found_ff <= 1'b0;
                  state_ff <= S_WAY_RD;
                  case (req_kind_type'(req_type))
                     REQ_SEARCH: begin
                        if (req_in_grid && goal_in_grid) begin
                           sx_cell_ff <= req_cell;
                           g_cell_ff  <= req_goal;
                           gx_ff      <= XB'(req_goal_x);
                           gy_ff      <= YB'(req_goal_y);
                           clr_ff     <= '0;
                           state_ff   <= S_S_CLR;
                        end
                     end
                     REQ_ADVANCE: begin
                        if (path_cnt_ff != '0 && way_idx_ext + CB'(1) < path_cnt_ff)
                           way_idx_ff <= way_idx_ff + 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            S_S_CLR: begin
               clr_ff <= clr_ff + CB'(1);
               if (clr_ff == CB'(CELLS - 1)) state_ff <= S_S_INIT;
            end
            S_S_INIT: begin
               open_cnt_ff <= CB'(1);
               scan_ff     <= '0;
               best_f_ff   <= UNREACH;
               best_ff     <= '0;
               state_ff    <= S_SCAN_A;
            end
            // open list scan: fetch entry, then its estimate
            S_SCAN_A: state_ff <= S_SCAN_B;
            S_SCAN_B: state_ff <= S_SCAN_C;
            S_SCAN_C: begin
               if (scan_ff == '0 || rd_f < best_f_ff) begin
                  best_f_ff <= rd_f;
                  best_ff   <= scan_ff;
                  node_ff   <= ol_rd;
               end
               if (scan_ff + CB'(1) < open_cnt_ff) begin
                  scan_ff  <= scan_ff + CB'(1);
                  state_ff <= S_SCAN_A;
               end else begin
                  if (!(scan_ff == '0 || rd_f < best_f_ff)) sh_ff <= best_ff + CB'(1);
                  else sh_ff <= scan_ff + CB'(1);
                  state_ff <= S_PICK;
               end
            end
            S_PICK: state_ff <= S_SHIFT_A;
            S_SHIFT_A: begin
               node_g_ff <= rd_g;
               if (sh_ff >= open_cnt_ff) begin
                  open_cnt_ff <= open_cnt_ff - CB'(1);
                  state_ff    <= S_NB_SEL;
                  dir_ff      <= 2'd0;
                  nb_ff       <= node_ff;
                  if (node_ff == g_cell_ff) begin
                     tr_p_ff   <= node_ff;
                     tr_len_ff <= '0;
                     state_ff  <= S_TR_RD;
                  end
               end else begin
                  state_ff <= S_SHIFT_B;
               end
            end
            S_SHIFT_B: begin
               sh_ff    <= sh_ff + CB'(1);
               state_ff <= S_SHIFT_A;
            end
            S_NB_SEL: begin
               // expanded cells keep visited clear: with a consistent estimate their
               // cost is already final, so the strict compare rejects them
               nb_ff <= nb_cell;
               if (nb_ok) state_ff <= S_NB_RD;
               else if (dir_ff == 2'd3) state_ff <= S_NB_CHK;
               else dir_ff <= dir_ff + 2'd1;
            end
            S_NB_RD: state_ff <= S_NB_CHK;
            S_NB_CHK: begin
               if (nb_ok && !rd_vis && !ob_rd && node_g_ff + CB'(1) < rd_g)
                  state_ff <= S_NB_WR;
               else if (dir_ff == 2'd3) begin
                  scan_ff   <= '0;
                  best_ff   <= '0;
                  state_ff  <= (open_cnt_ff == '0) ? S_DONE : S_SCAN_A;
               end else begin
                  dir_ff   <= dir_ff + 2'd1;
                  state_ff <= S_NB_SEL;
               end
            end
            S_NB_WR: begin
               if (rd_g == UNREACH && open_cnt_ff < CB'(CELLS))
                  open_cnt_ff <= open_cnt_ff + CB'(1);
               if (dir_ff == 2'd3) begin
                  scan_ff  <= '0;
                  best_ff  <= '0;
                  state_ff <= S_SCAN_A;
               end else begin
                  dir_ff   <= dir_ff + 2'd1;
                  state_ff <= S_NB_SEL;
               end
            end
            S_TR_RD: state_ff <= S_TR_WR;
            S_TR_WR: begin
               tr_len_ff <= tr_len_ff + CB'(1);
               tr_p_ff   <= rd_par;
               if (!rd_pv || tr_len_ff + CB'(1) >= CB'(CELLS)) begin
                  tr_i_ff  <= '0;
                  state_ff <= S_TR_CP_A;
               end else begin
                  state_ff <= S_TR_RD;
               end
            end
            S_TR_CP_A: state_ff <= S_TR_CP_B;
            S_TR_CP_B: begin
               tr_i_ff <= tr_i_ff + CB'(1);
               if (tr_i_ff + CB'(1) >= tr_len_ff) begin
                  path_cnt_ff <= tr_len_ff;
                  way_idx_ff  <= '0;
                  found_ff    <= 1'b1;
                  state_ff    <= S_WAY_RD;
               end else begin
                  state_ff <= S_TR_CP_A;
               end
            end
            S_DONE:   state_ff <= S_WAY_RD;
            S_WAY_RD: state_ff <= S_WAY_OUT;
            S_WAY_OUT: begin
               rsp_strobe      <= 1'b1;
               rsp_found       <= found_ff;
               rsp_path_length <= LEN_BITS'(path_cnt_ff);
               rsp_way_valid   <= path_cnt_ff != '0 && way_idx_ext < path_cnt_ff;
               if (path_cnt_ff != '0 && way_idx_ext < path_cnt_ff) begin
                  rsp_way_x <= COORD_BITS'(ps_rd[XB-1:0]);
                  rsp_way_y <= COORD_BITS'(ps_rd[AB-1:XB]);
               end else begin
                  rsp_way_x <= '0;
                  rsp_way_y <= '0;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe longer than a cycle");
   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("strobe while busy");
   a_way_in_path: assert property (@(posedge clock) disable iff (reset)
      path_cnt_ff != '0 |-> way_idx_ext < path_cnt_ff) else $error("index past path");
   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_cnt_ff <= CB'(CELLS)) else $error("open list overflow");
endmodule
`default_nettype wire

// File: rtl/core/gasp_ram.sv
`default_nettype none
module gasp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: tb/grid_astar_path_search_test.sv
`default_nettype none
module grid_astar_path_search_test;
   import gasp_pkg::*;

   localparam int GRID_COLS  = 32;
   localparam int GRID_ROWS  = 32;
   localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
   // a full-grid search: a sweep of all 1k cells plus up to 1k expansions, each scanning and
   // shifting an open list of up to 1k entries, must finish within this limit
   localparam int STALL_LIMIT = 20_000_000;
   localparam int SETTLE_CYCLES = 40;

   // one request word as driven onto the req_ ports
   typedef struct {
      req_kind_type kind;
      logic [COORD_BITS-1:0] cell_x;
      logic [COORD_BITS-1:0] cell_y;
      logic blocked;
      logic [COORD_BITS-1:0] goal_x;
      logic [COORD_BITS-1:0] goal_y;
   } path_req_type;

   // one answer word as seen on the rsp_ ports
   typedef struct {
      logic found;
      logic [LEN_BITS-1:0] path_length;
      logic [COORD_BITS-1:0] way_x;
      logic [COORD_BITS-1:0] way_y;
      logic way_valid;
   } path_rsp_type;

   // shadow of the search engine plus the queue of answers still owed by the block
   class path_scoreboard;
      localparam int unsigned NONE = 32'hFFFF_FFFF;
      int unsigned cols_reg, rows_reg;
      bit wall[CELL_COUNT];
      bit seen[CELL_COUNT];
      int unsigned g_cost[CELL_COUNT];
      int unsigned score[CELL_COUNT];
      int unsigned came_from[CELL_COUNT];
      int unsigned frontier[$];
      int unsigned route[CELL_COUNT];
      int unsigned route_len;
      int unsigned way_idx;
      path_rsp_type owed[$];
      int errors;

      function new();
         cols_reg = 32;
         rows_reg = 32;
         route_len = 0;
         way_idx = 0;
         errors = 0;
         foreach (wall[i]) wall[i] = 0;
      endfunction

      function int unsigned clamp_dim(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         return (v > hi) ? hi : v;
      endfunction

      function void write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         if (idx == CSR_WIDTH_IDX) cols_reg = 32'(val);
         else rows_reg = 32'(val);
      endfunction

      function int unsigned gap(int unsigned a, int unsigned b);
         return (a > b) ? a - b : b - a;
      endfunction

      function void relax(int unsigned from, int unsigned to, int unsigned gx, int unsigned gy);
         int unsigned ng;
         if (seen[to] || wall[to]) return;
         ng = g_cost[from] + 1;
         if (ng < g_cost[to]) begin
            if (g_cost[to] == NONE && frontier.size() < CELL_COUNT) frontier = {frontier, to};
            came_from[to] = from;
            g_cost[to] = ng;
            score[to] = ng + gap(to % GRID_COLS, gx) + gap(to / GRID_COLS, gy);
         end
      endfunction

      function bit search(int unsigned sx, int unsigned sy, int unsigned gx, int unsigned gy);
         int unsigned w, h, s, g, n, best, len, p;
         int unsigned trail[$];
         w = clamp_dim(cols_reg, GRID_COLS);
         h = clamp_dim(rows_reg, GRID_ROWS);
         if (sx >= w || sy >= h || gx >= w || gy >= h) return 0;
         s = sy * GRID_COLS + sx;
         g = gy * GRID_COLS + gx;
         wall[s] = 0;
         wall[g] = 0;
         for (int i = 0; i < CELL_COUNT; i++) begin
            seen[i] = 0;
            g_cost[i] = NONE;
            score[i] = NONE;
            came_from[i] = NONE;
         end
         seen[s] = 1;
         seen[g] = 0;
         g_cost[s] = 0;
         frontier = {s};
         while (frontier.size() > 0) begin
            best = 0;
            // strict compare keeps the earliest inserted entry on a tie
            for (int i = 1; i < frontier.size(); i++)
               if (score[frontier[i]] < score[frontier[best]]) best = i;
            n = frontier[best];
            frontier.delete(best);
            seen[n] = 1;
            if (n == g) begin
               trail = {};
               p = n;
               while (p != NONE && trail.size() < CELL_COUNT) begin
                  trail.push_front(p);
                  p = came_from[p];
               end
               len = trail.size();
               foreach (trail[i]) route[i] = trail[i];
               route_len = len;
               way_idx = 0;
               return 1;
            end
            if (n % GRID_COLS + 1 < w) relax(n, n + 1, gx, gy);
            if (n / GRID_COLS + 1 < h) relax(n, n + GRID_COLS, gx, gy);
            if (n % GRID_COLS >= 1) relax(n, n - 1, gx, gy);
            if (n / GRID_COLS >= 1) relax(n, n - GRID_COLS, gx, gy);
         end
         return 0;
      endfunction

      // accepted request word: update the shadow and queue the answer it owes
      function void note_request(path_req_type r);
         path_rsp_type a;
         a.found = 0;
         case (r.kind)
            REQ_SET_CELL: begin
               if (r.cell_x < clamp_dim(cols_reg, GRID_COLS) &&
                   r.cell_y < clamp_dim(rows_reg, GRID_ROWS))
                  wall[r.cell_y * GRID_COLS + r.cell_x] = r.blocked;
            end
            REQ_SEARCH: a.found = search(r.cell_x, r.cell_y, r.goal_x, r.goal_y);
            REQ_ADVANCE: begin
               if (route_len > 0 && way_idx + 1 < route_len) way_idx++;
            end
            default: ;
         endcase
         a.path_length = LEN_BITS'(route_len);
         a.way_valid = (route_len > 0 && way_idx < route_len);
         a.way_x = a.way_valid ? COORD_BITS'(route[way_idx] % GRID_COLS) : '0;
         a.way_y = a.way_valid ? COORD_BITS'(route[way_idx] / GRID_COLS) : '0;
         owed = {owed, a};
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_result(path_rsp_type got);
         path_rsp_type want;
         if (owed.size() == 0) begin
            report("answer word with nothing outstanding");
            return;
         end
         want = owed.pop_front();
         if (got.found !== want.found)
            report($sformatf("found %0b want %0b", got.found, want.found));
         if (got.path_length !== want.path_length)
            report($sformatf("path_length %0d want %0d", got.path_length, want.path_length));
         if (got.way_x !== want.way_x)
            report($sformatf("way_x %0d want %0d", got.way_x, want.way_x));
         if (got.way_y !== want.way_y)
            report($sformatf("way_y %0d want %0d", got.way_y, want.way_y));
         if (got.way_valid !== want.way_valid)
            report($sformatf("way_valid %0b want %0b", got.way_valid, want.way_valid));
      endtask
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_type;
   logic [COORD_BITS-1:0] req_cell_x, req_cell_y, req_goal_x, req_goal_y;
   logic req_blocked;
   logic rsp_strobe, rsp_found, rsp_way_valid;
   logic [LEN_BITS-1:0] rsp_path_length;
   logic [COORD_BITS-1:0] rsp_way_x, rsp_way_y;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   path_scoreboard board;
   bit idle_allowed;
   int stall_count;

   grid_astar_path_search dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_cell_x(req_cell_x),
      .req_cell_y(req_cell_y),
      .req_blocked(req_blocked),
      .req_goal_x(req_goal_x),
      .req_goal_y(req_goal_y),
      .rsp_strobe(rsp_strobe),
      .rsp_found(rsp_found),
      .rsp_path_length(rsp_path_length),
      .rsp_way_x(rsp_way_x),
      .rsp_way_y(rsp_way_y),
      .rsp_way_valid(rsp_way_valid),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // answer words are sampled at the rising edge that ends their strobe cycle
   always @(posedge clock) begin
      path_rsp_type got;
      if (!reset && rsp_strobe) begin
         got.found = rsp_found;
         got.path_length = rsp_path_length;
         got.way_x = rsp_way_x;
         got.way_y = rsp_way_y;
         got.way_valid = rsp_way_valid;
         board.check_result(got);
      end
   end

   // watchdog: cycles with no word moving on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // present one request word, hold it until the block takes it
   task send(path_req_type r);
      start = 1;
      req_type = r.kind;
      req_cell_x = r.cell_x;
      req_cell_y = r.cell_y;
      req_blocked = r.blocked;
      req_goal_x = r.goal_x;
      req_goal_y = r.goal_y;
      do @(posedge clock); while (busy);
      board.note_request(r);
      @(negedge clock);
      // random idle burst on the request side, skipped in the quiet tail of the run
      if (idle_allowed && $urandom_range(0, 2) == 0) begin
         start = 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task put(req_kind_type k, int cx = 0, int cy = 0, bit b = 0, int gx = 0, int gy = 0);
      path_req_type r;
      r.kind = k;
      r.cell_x = COORD_BITS'(cx);
      r.cell_y = COORD_BITS'(cy);
      r.blocked = b;
      r.goal_x = COORD_BITS'(gx);
      r.goal_y = COORD_BITS'(gy);
      send(r);
   endtask

   // drain every outstanding answer, then let the engine settle
   task drain();
      start = 0;
      while (board.owed.size() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_valid = 1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      board.write_csr(idx, val);
      @(negedge clock);
      csr_valid = 0;
   endtask

   // mostly well-formed traffic inside the grid in use, with some raw coordinates
   task random_phase(int count);
      int unsigned w, h, pick;
      path_req_type r;
      w = board.clamp_dim(board.cols_reg, GRID_COLS);
      h = board.clamp_dim(board.rows_reg, GRID_ROWS);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         r.kind = (pick < 35) ? REQ_SET_CELL : (pick < 60) ? REQ_SEARCH :
                  (pick < 75) ? REQ_READ_WAY : REQ_ADVANCE;
         r.blocked = ($urandom_range(0, 99) < 35);
         if ($urandom_range(0, 9) < 8) begin
            r.cell_x = COORD_BITS'($urandom_range(0, w - 1));
            r.cell_y = COORD_BITS'($urandom_range(0, h - 1));
            r.goal_x = COORD_BITS'($urandom_range(0, w - 1));
            r.goal_y = COORD_BITS'($urandom_range(0, h - 1));
         end else begin
            r.cell_x = COORD_BITS'($urandom);
            r.cell_y = COORD_BITS'($urandom);
            r.goal_x = COORD_BITS'($urandom);
            r.goal_y = COORD_BITS'($urandom);
         end
         send(r);
      end
   endtask

   initial begin
      board = new();
      idle_allowed = 1;
      reset = 1;
      start = 0;
      req_type = REQ_READ_WAY;
      req_cell_x = 0;
      req_cell_y = 0;
      req_blocked = 0;
      req_goal_x = 0;
      req_goal_y = 0;
      csr_valid = 0;
      csr_index = CSR_WIDTH_IDX;
      csr_data = 0;
      repeat (10) @(negedge clock);
      reset = 0;

      // directed: full 32x32 grid after reset
      put(REQ_READ_WAY);                       // nothing stored yet
      put(REQ_ADVANCE);                        // advance with no path
      put(REQ_SEARCH, 7, 9, 0, 7, 9);          // start equals goal
      put(REQ_ADVANCE);                        // already on last cell
      put(REQ_SET_CELL, 31, 31, 1);
      put(REQ_SET_CELL, 2, 0, 1);
      put(REQ_SET_CELL, 2, 1, 1);
      put(REQ_SEARCH, 0, 0, 0, 4, 0);          // detour round a short wall
      put(REQ_ADVANCE);
      put(REQ_ADVANCE);
      put(REQ_READ_WAY);
      put(REQ_SEARCH, 31, 31, 1, 24, 26);      // blocked start gets cleared
      put(REQ_SET_CELL, 30, 0, 1);
      put(REQ_SET_CELL, 31, 1, 1);
      put(REQ_SEARCH, 0, 31, 0, 31, 0);        // goal walled in: old path kept
      put(REQ_READ_WAY);
      for (int i = 0; i < 4; i++) put(REQ_ADVANCE);
      put(REQ_SEARCH, 0, 0, 0, 31, 31);        // corner to corner
      put(REQ_SET_CELL, 31, 31, 0);
      put(REQ_READ_WAY);

      // pause the request side until every answer is in, then reconfigure
      drain();
      write_csr(CSR_WIDTH_IDX, 0);             // zero counts as one
      write_csr(CSR_HEIGHT_IDX, 1);
      put(REQ_SEARCH, 0, 0, 0, 0, 0);
      put(REQ_SEARCH, 1, 0, 0, 0, 0);          // start off the grid
      put(REQ_SEARCH, 0, 0, 0, 0, 1);          // goal off the grid
      put(REQ_SET_CELL, 0, 1, 1);              // ignored, off the grid
      random_phase(12);

      drain();
      write_csr(CSR_WIDTH_IDX, 63);            // clamps to the maximum
      write_csr(CSR_HEIGHT_IDX, 5);
      random_phase(25);

      drain();
      write_csr(CSR_WIDTH_IDX, 6);
      write_csr(CSR_HEIGHT_IDX, 33);           // clamps to the maximum
      random_phase(20);

      drain();
      write_csr(CSR_WIDTH_IDX, 8);
      write_csr(CSR_HEIGHT_IDX, 8);
      random_phase(40);

      drain();
      write_csr(CSR_WIDTH_IDX, 32);
      write_csr(CSR_HEIGHT_IDX, 32);
      idle_allowed = 0;                        // back-to-back tail
      start = 0;
      @(negedge clock);
      random_phase(15);

      start = 0;
      for (int n = 0; n < STALL_LIMIT && board.owed.size() > 0; n++) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (board.errors == 0 && board.owed.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
